// ----- rtl/rpg_pkg.sv -----
// Shared types, constants and the microcode ROM for the random permutation generator.
// No dependencies; rpg_useq, rpg_datapath and the top level import this package.
package rpg_pkg;

    localparam int MAX_LEN    = 32;
    localparam int IDX_W      = $clog2(MAX_LEN);
    localparam int CNT_W      = IDX_W + 1;
    localparam int UPC_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PERM_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHUFFLE_ROUNDS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EMIT_INVERSE   = 2'd2;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LATCH,
        OP_SHIFT,
        OP_TAKE_DRAW,
        OP_SET_J0,
        OP_RD_J,
        OP_WR_I_RD,
        OP_WR_J_I,
        OP_RD_I,
        OP_RD_T_TMP,
        OP_WR_T_TMP,
        OP_ENTER_SHUF,
        OP_NEXT_RND,
        OP_CLR_E,
        OP_RD_E,
        OP_WR_INV,
        OP_RD_OUT,
        OP_PUSH,
        OP_RESTART
    } op_t;

    typedef enum logic [3:0] {
        C_NONE,
        C_ALWAYS,
        C_NO_INPUT,
        C_BUILD_DONE,
        C_IS_BUILD,
        C_ROUNDS_DONE,
        C_ROUND_END,
        C_D_LE1,
        C_USED,
        C_NOT_FULL,
        C_REJECT,
        C_IS_SHUF,
        C_E_DONE,
        C_OUT_STALL
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [UPC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic no_input;
        logic build_done;
        logic is_build;
        logic rounds_done;
        logic round_end;
        logic d_le1;
        logic used;
        logic not_full;
        logic reject;
        logic e_done;
        logic out_stall;
    } flags_t;

    // microprogram labels
    localparam logic [UPC_W-1:0] U_IDLE      = 5'd0;
    localparam logic [UPC_W-1:0] U_LOOP      = 5'd1;
    localparam logic [UPC_W-1:0] U_DRAW      = 5'd5;
    localparam logic [UPC_W-1:0] U_APPLY     = 5'd10;
    localparam logic [UPC_W-1:0] U_SWAP      = 5'd13;
    localparam logic [UPC_W-1:0] U_TO_SHUF   = 5'd17;
    localparam logic [UPC_W-1:0] U_NEXT_RND  = 5'd18;
    localparam logic [UPC_W-1:0] U_APPLY0    = 5'd19;
    localparam logic [UPC_W-1:0] U_EMIT      = 5'd20;
    localparam logic [UPC_W-1:0] U_INV_LOOP  = 5'd21;
    localparam logic [UPC_W-1:0] U_OUT_START = 5'd23;
    localparam logic [UPC_W-1:0] U_OUT_LOOP  = 5'd24;
    localparam logic [UPC_W-1:0] U_PUSH      = 5'd25;
    localparam logic [UPC_W-1:0] U_RESTART   = 5'd27;

    function automatic uword_t urom(input logic [UPC_W-1:0] addr);
        uword_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: U_IDLE};
        unique case (addr)
            5'd0:  w = '{op: OP_LATCH,      cond: C_NO_INPUT,    target: U_IDLE};
            5'd1:  w = '{op: OP_NOP,        cond: C_BUILD_DONE,  target: U_TO_SHUF};
            5'd2:  w = '{op: OP_NOP,        cond: C_IS_BUILD,    target: U_DRAW};
            5'd3:  w = '{op: OP_NOP,        cond: C_ROUNDS_DONE, target: U_EMIT};
            5'd4:  w = '{op: OP_NOP,        cond: C_ROUND_END,   target: U_NEXT_RND};
            5'd5:  w = '{op: OP_NOP,        cond: C_D_LE1,       target: U_APPLY0};
            5'd6:  w = '{op: OP_NOP,        cond: C_USED,        target: U_IDLE};
            5'd7:  w = '{op: OP_SHIFT,      cond: C_NONE,        target: U_IDLE};
            5'd8:  w = '{op: OP_NOP,        cond: C_NOT_FULL,    target: U_LOOP};
            5'd9:  w = '{op: OP_TAKE_DRAW,  cond: C_REJECT,      target: U_LOOP};
            5'd10: w = '{op: OP_RD_J,       cond: C_IS_SHUF,     target: U_SWAP};
            5'd11: w = '{op: OP_WR_I_RD,    cond: C_NONE,        target: U_IDLE};
            5'd12: w = '{op: OP_WR_J_I,     cond: C_ALWAYS,      target: U_LOOP};
            5'd13: w = '{op: OP_RD_I,       cond: C_NONE,        target: U_IDLE};
            5'd14: w = '{op: OP_RD_T_TMP,   cond: C_NONE,        target: U_IDLE};
            5'd15: w = '{op: OP_WR_I_RD,    cond: C_NONE,        target: U_IDLE};
            5'd16: w = '{op: OP_WR_T_TMP,   cond: C_ALWAYS,      target: U_LOOP};
            5'd17: w = '{op: OP_ENTER_SHUF, cond: C_ALWAYS,      target: U_LOOP};
            5'd18: w = '{op: OP_NEXT_RND,   cond: C_ALWAYS,      target: U_LOOP};
            5'd19: w = '{op: OP_SET_J0,     cond: C_ALWAYS,      target: U_APPLY};
            5'd20: w = '{op: OP_CLR_E,      cond: C_NONE,        target: U_IDLE};
            5'd21: w = '{op: OP_RD_E,       cond: C_E_DONE,      target: U_OUT_START};
            5'd22: w = '{op: OP_WR_INV,     cond: C_ALWAYS,      target: U_INV_LOOP};
            5'd23: w = '{op: OP_CLR_E,      cond: C_NONE,        target: U_IDLE};
            5'd24: w = '{op: OP_RD_OUT,     cond: C_E_DONE,      target: U_RESTART};
            5'd25: w = '{op: OP_PUSH,       cond: C_OUT_STALL,   target: U_PUSH};
            5'd26: w = '{op: OP_NOP,        cond: C_ALWAYS,      target: U_OUT_LOOP};
            5'd27: w = '{op: OP_RESTART,    cond: C_ALWAYS,      target: U_IDLE};
            default: w = '{op: OP_NOP,      cond: C_ALWAYS,      target: U_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/rpg_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpg_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 5
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/rpg_useq.sv -----
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
// Depends on rpg_pkg for the control word, the flags and the ROM.
module rpg_useq
    import rpg_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  flags_t flags,
    output op_t    op,
    output logic   in_ready
);

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    uword_t           uw;
    logic             jump;

    assign uw       = urom(upc_reg);
    assign op       = uw.op;
    assign in_ready = (upc_reg == U_IDLE);

    always_comb
    begin
        unique case (uw.cond)
            C_NONE:        jump = 1'b0;
            C_ALWAYS:      jump = 1'b1;
            C_NO_INPUT:    jump = flags.no_input;
            C_BUILD_DONE:  jump = flags.build_done;
            C_IS_BUILD:    jump = flags.is_build;
            C_ROUNDS_DONE: jump = flags.rounds_done;
            C_ROUND_END:   jump = flags.round_end;
            C_D_LE1:       jump = flags.d_le1;
            C_USED:        jump = flags.used;
            C_NOT_FULL:    jump = flags.not_full;
            C_REJECT:      jump = flags.reject;
            C_IS_SHUF:     jump = !flags.is_build;
            C_E_DONE:      jump = flags.e_done;
            C_OUT_STALL:   jump = flags.out_stall;
            default:       jump = 1'b0;
        endcase
        upc_next = jump ? uw.target : upc_reg + UPC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    // an accepted transaction always leaves the idle step
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready && !flags.no_input) |=> !in_ready)
        else $error("sequencer stayed idle after accepting a bit");

endmodule

// ----- rtl/rpg_datapath.sv -----
// Datapath: configuration registers, draw and index registers, permutation and inverse
// memories, and the output register. Depends on rpg_pkg and rpg_ram.
module rpg_datapath
    import rpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  op_t                   op,
    input  logic                  in_valid,
    input  logic                  in_bit,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [IDX_W-1:0]      out_position,
    output logic [IDX_W-1:0]      out_element,
    output logic                  out_last,
    output flags_t                flags
);

    // configuration
    logic [CNT_W-1:0] perm_length_reg;
    logic [3:0]       shuffle_rounds_reg;
    logic             emit_inverse_reg;

    // sequencing state
    logic             phase_build_reg;
    logic [CNT_W-1:0] step_index_reg;
    logic [3:0]       round_count_reg;
    logic [CNT_W-1:0] draw_value_reg;
    logic [2:0]       draw_bits_reg;
    logic             used_reg;
    logic             bit_reg;
    logic [IDX_W-1:0] j_reg;
    logic [IDX_W-1:0] tmp_reg;
    logic [CNT_W-1:0] e_reg;

    // output register
    logic             out_valid_reg;
    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] elem_reg;
    logic             last_reg;

    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] d;
    logic [2:0]       k;
    logic [CNT_W-1:0] t;
    logic             stall;
    logic             push;

    logic             perm_we;
    logic [IDX_W-1:0] perm_waddr;
    logic [IDX_W-1:0] perm_wdata;
    logic             perm_re;
    logic [IDX_W-1:0] perm_raddr;
    logic [IDX_W-1:0] perm_rdata;
    logic             inv_we;
    logic             inv_re;
    logic [IDX_W-1:0] inv_rdata;

    // ceil(log2 d) for d up to MAX_LEN
    function automatic logic [2:0] bits_for(input logic [CNT_W-1:0] dv);
        logic [2:0] r;
        r = 3'd0;
        for (int b = 0; b < CNT_W; b++)
        begin
            if ((CNT_W'(1) << b) < dv)
            begin
                r = 3'(b + 1);
            end
        end
        return r;
    endfunction

    always_comb
    begin
        if (perm_length_reg == '0)
        begin
            n = CNT_W'(1);
        end
        else if (perm_length_reg > CNT_W'(MAX_LEN))
        begin
            n = CNT_W'(MAX_LEN);
        end
        else
        begin
            n = perm_length_reg;
        end
    end

    assign d     = phase_build_reg ? step_index_reg + CNT_W'(1) : n - step_index_reg;
    assign k     = bits_for(d);
    assign t     = step_index_reg + {1'b0, j_reg};
    assign stall = out_valid_reg && !out_ready;
    assign push  = (op == OP_PUSH) && !stall;

    assign flags.no_input    = !in_valid;
    assign flags.build_done  = phase_build_reg && (step_index_reg >= n);
    assign flags.is_build    = phase_build_reg;
    assign flags.rounds_done = (round_count_reg >= shuffle_rounds_reg);
    assign flags.round_end   = (step_index_reg + CNT_W'(1) >= n);
    assign flags.d_le1       = (d <= CNT_W'(1));
    assign flags.used        = used_reg;
    assign flags.not_full    = (draw_bits_reg < k);
    assign flags.reject      = (draw_value_reg >= d);
    assign flags.e_done      = (e_reg >= n);
    assign flags.out_stall   = stall;

    // permutation memory port control
    always_comb
    begin
        perm_we    = 1'b0;
        perm_waddr = step_index_reg[IDX_W-1:0];
        perm_wdata = perm_rdata;
        perm_re    = 1'b0;
        perm_raddr = j_reg;
        unique case (op)
            OP_RD_J:
            begin
                perm_re = 1'b1;
            end
            OP_RD_I:
            begin
                perm_re    = 1'b1;
                perm_raddr = step_index_reg[IDX_W-1:0];
            end
            OP_RD_T_TMP:
            begin
                perm_re    = 1'b1;
                perm_raddr = t[IDX_W-1:0];
            end
            OP_RD_E, OP_RD_OUT:
            begin
                perm_re    = 1'b1;
                perm_raddr = e_reg[IDX_W-1:0];
            end
            OP_WR_I_RD:
            begin
                perm_we = 1'b1;
            end
            OP_WR_J_I:
            begin
                perm_we    = 1'b1;
                perm_waddr = j_reg;
                perm_wdata = step_index_reg[IDX_W-1:0];
            end
            OP_WR_T_TMP:
            begin
                perm_we    = 1'b1;
                perm_waddr = t[IDX_W-1:0];
                perm_wdata = tmp_reg;
            end
            default:
            begin
                perm_we = 1'b0;
            end
        endcase
    end

    assign inv_we = (op == OP_WR_INV);
    assign inv_re = (op == OP_RD_OUT);

    rpg_ram #(
        .DEPTH (MAX_LEN),
        .WIDTH (IDX_W)
    ) u_perm_ram (
        .clk   (clk),
        .we    (perm_we),
        .waddr (perm_waddr),
        .wdata (perm_wdata),
        .re    (perm_re),
        .raddr (perm_raddr),
        .rdata (perm_rdata)
    );

    rpg_ram #(
        .DEPTH (MAX_LEN),
        .WIDTH (IDX_W)
    ) u_inv_ram (
        .clk   (clk),
        .we    (inv_we),
        .waddr (perm_rdata),
        .wdata (e_reg[IDX_W-1:0]),
        .re    (inv_re),
        .raddr (e_reg[IDX_W-1:0]),
        .rdata (inv_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            perm_length_reg    <= CNT_W'(MAX_LEN);
            shuffle_rounds_reg <= '0;
            emit_inverse_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            // drop writes to unused indexes
            unique case (cfg_index)
                REG_PERM_LENGTH:
                begin
                    perm_length_reg <= cfg_data;
                end
                REG_SHUFFLE_ROUNDS:
                begin
                    shuffle_rounds_reg <= cfg_data[3:0];
                end
                REG_EMIT_INVERSE:
                begin
                    emit_inverse_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_build_reg <= 1'b1;
            step_index_reg  <= '0;
            round_count_reg <= '0;
            draw_value_reg  <= '0;
            draw_bits_reg   <= '0;
            used_reg        <= 1'b0;
            e_reg           <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            unique case (op)
                OP_LATCH:
                begin
                    if (in_valid)
                    begin
                        used_reg <= 1'b0;
                    end
                end
                OP_SHIFT:
                begin
                    used_reg       <= 1'b1;
                    draw_value_reg <= {draw_value_reg[CNT_W-2:0], bit_reg};
                    draw_bits_reg  <= draw_bits_reg + 3'd1;
                end
                OP_TAKE_DRAW:
                begin
                    draw_value_reg <= '0;
                    draw_bits_reg  <= '0;
                end
                OP_WR_J_I, OP_WR_T_TMP:
                begin
                    step_index_reg <= step_index_reg + CNT_W'(1);
                end
                OP_ENTER_SHUF:
                begin
                    phase_build_reg <= 1'b0;
                    step_index_reg  <= '0;
                    round_count_reg <= '0;
                    draw_value_reg  <= '0;
                    draw_bits_reg   <= '0;
                end
                OP_NEXT_RND:
                begin
                    round_count_reg <= round_count_reg + 4'd1;
                    step_index_reg  <= '0;
                    draw_value_reg  <= '0;
                    draw_bits_reg   <= '0;
                end
                OP_RESTART:
                begin
                    phase_build_reg <= 1'b1;
                    step_index_reg  <= '0;
                    round_count_reg <= '0;
                    draw_value_reg  <= '0;
                    draw_bits_reg   <= '0;
                end
                OP_CLR_E:
                begin
                    e_reg <= '0;
                end
                OP_WR_INV:
                begin
                    e_reg <= e_reg + CNT_W'(1);
                end
                OP_PUSH:
                begin
                    if (!stall)
                    begin
                        e_reg <= e_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                    e_reg <= e_reg;
                end
            endcase

            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (op == OP_LATCH && in_valid)
        begin
            bit_reg <= in_bit;
        end
        if (op == OP_TAKE_DRAW)
        begin
            j_reg <= draw_value_reg[IDX_W-1:0];
        end
        else if (op == OP_SET_J0)
        begin
            j_reg <= '0;
        end
        if (op == OP_RD_T_TMP)
        begin
            tmp_reg <= perm_rdata;
        end
        if (push)
        begin
            pos_reg  <= e_reg[IDX_W-1:0];
            elem_reg <= emit_inverse_reg ? inv_rdata : perm_rdata;
            last_reg <= (e_reg + CNT_W'(1) == n);
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_position = pos_reg;
    assign out_element  = elem_reg;
    assign out_last     = last_reg;

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_index_reg <= CNT_W'(MAX_LEN))
        else $error("step index ran past the table");

    a_draw_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
        draw_bits_reg <= 3'(IDX_W))
        else $error("draw collected more bits than any bound needs");

    a_out_from_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(op == OP_PUSH))
        else $error("output became valid outside the emit loop");

endmodule

// ----- rtl/random_permutation_generator_top.sv -----
// Top level of the random permutation generator: stream ports and configuration port.
// Depends on rpg_pkg, rpg_useq and rpg_datapath.
//
// Each accepted transaction on the s_axis side delivers one random bit. A microcoded
// sequencer walks an inside-out Fisher-Yates build and then shuffle_rounds forward
// shuffle passes, each draw taking ceil(log2 d) bits with rejection. A bit is taken
// only at the idle step. The sequencer runs one control step per cycle, holding the
// push step while the sink stalls, and a swap is two reads and two writes of the
// permutation memory in turn. When the last draw is done the block fills the inverse
// table and emits n entries on m_axis, then starts a new build. Configuration writes
// are always taken; change registers only while the block waits for a bit and no
// result is outstanding.
module random_permutation_generator_top
    import rpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [0] random_bit, [7:1] zero
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,   // [4:0] position, [9:5] element, [15:10] zero
    output logic                  m_axis_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    op_t              op;
    flags_t           flags;
    logic [IDX_W-1:0] position;
    logic [IDX_W-1:0] element;

    assign cfg_ready = 1'b1;

    rpg_useq u_useq (
        .clk      (clk),
        .rst_n    (rst_n),
        .flags    (flags),
        .op       (op),
        .in_ready (s_axis_tready)
    );

    rpg_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .in_valid     (s_axis_tvalid),
        .in_bit       (s_axis_tdata[0]),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_position (position),
        .out_element  (element),
        .out_last     (m_axis_tlast),
        .flags        (flags)
    );

    assign m_axis_tdata = {6'b0, element, position};

endmodule
